>>> rtl/core/ckhl_pkg.sv
`default_nettype none

package ckhl_pkg;

  localparam int MAX_LINE = 4096;
  localparam int RUN_CAP_INT = (MAX_LINE < 8191) ? MAX_LINE : 8191;
  localparam int LEN_W = 13;
  localparam logic [LEN_W-1:0] RUN_CAP = LEN_W'(RUN_CAP_INT);
  localparam logic [LEN_W-1:0] PREFIX_CHARS = LEN_W'(8);
  localparam logic [LEN_W-1:0] COMMENT_START = (LEN_W'(2) < RUN_CAP) ? LEN_W'(2) : RUN_CAP;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;

  localparam logic [1:0] COLOR_PLAIN = 2'd0;
  localparam logic [1:0] COLOR_KEYWORD = 2'd1;
  localparam logic [1:0] COLOR_TYPE = 2'd2;
  localparam logic [1:0] COLOR_COMMENT = 2'd3;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int NUM_KW = 13;
  localparam int NUM_TY = 19;

  typedef struct packed {
    logic [1:0]       color;
    logic [LEN_W-1:0] run_length;
    logic             line_end;
    logic             last;
  } result_t;

  localparam logic [63:0] KW_WORD [NUM_KW] = '{
    64'("if"), 64'("else"), 64'("while"), 64'("for"), 64'("do"), 64'("switch"),
    64'("case"), 64'("default"), 64'("break"), 64'("continue"), 64'("return"),
    64'("goto"), 64'("sizeof")
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd2, 4'd4, 4'd5, 4'd3, 4'd2, 4'd6, 4'd4, 4'd7, 4'd5, 4'd8, 4'd6, 4'd4, 4'd6
  };

  localparam logic [63:0] TY_WORD [NUM_TY] = '{
    64'("int"), 64'("char"), 64'("float"), 64'("double"), 64'("long"), 64'("short"),
    64'("unsigned"), 64'("signed"), 64'("void"), 64'("struct"), 64'("enum"),
    64'("union"), 64'("auto"), 64'("register"), 64'("static"), 64'("extern"),
    64'("const"), 64'("volatile"), 64'("typedef")
  };
  localparam logic [3:0] TY_LEN [NUM_TY] = '{
    4'd3, 4'd4, 4'd5, 4'd6, 4'd4, 4'd5, 4'd8, 4'd6, 4'd4, 4'd6, 4'd4,
    4'd5, 4'd4, 4'd8, 4'd6, 4'd6, 4'd5, 4'd8, 4'd7
  };

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || (c == CHAR_UNDERSCORE);
  endfunction

  function automatic logic [1:0] word_color(input logic [63:0] prefix,
                                            input logic [LEN_W-1:0] len);
    logic kw_hit;
    logic ty_hit;
    kw_hit = 1'b0;
    ty_hit = 1'b0;
    for (int i = 0; i < NUM_KW; i++) begin
      if (len == LEN_W'(KW_LEN[i]) && prefix == KW_WORD[i]) kw_hit = 1'b1;
    end
    for (int i = 0; i < NUM_TY; i++) begin
      if (len == LEN_W'(TY_LEN[i]) && prefix == TY_WORD[i]) ty_hit = 1'b1;
    end
    if (kw_hit) return COLOR_KEYWORD;
    else if (ty_hit) return COLOR_TYPE;
    else return COLOR_PLAIN;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ckhl_result_fifo.sv
`default_nettype none

module ckhl_result_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [1:0]          push_n,
  input  wire ckhl_pkg::result_t   push0,
  input  wire ckhl_pkg::result_t   push1,
  output logic                     room2,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ckhl_pkg::result_t        out_res
);

  ckhl_pkg::result_t mem [ckhl_pkg::FIFO_DEPTH];
  logic [ckhl_pkg::PTR_W-1:0] head;
  logic [ckhl_pkg::PTR_W-1:0] tail;
  logic [ckhl_pkg::CNT_W-1:0] count;
  logic pop;

  assign pop = out_valid && !out_stall;
  assign out_valid = (count != '0);
  assign room2 = (count <= ckhl_pkg::CNT_W'(ckhl_pkg::FIFO_DEPTH - 2));
  assign out_res = mem[head];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[tail] <= push0;
    if (push_n == 2'd2) mem[tail + ckhl_pkg::PTR_W'(1)] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      if (pop) head <= head + ckhl_pkg::PTR_W'(1);
      tail <= tail + ckhl_pkg::PTR_W'(push_n);
      count <= count + ckhl_pkg::CNT_W'(push_n) - ckhl_pkg::CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/c_keyword_highlight_lexer.sv
// Streaming C syntax highlighter. Send one character of a line per item on
// char_code; newline ends the line. Each accepted character is classified in
// the cycle it is taken and yields zero, one or two run-length results
// (plain, keyword, type or comment, plus a line-end marker with length 0);
// the last result caused by a character has last set. Results queue in a
// four-entry buffer, and a character is taken whenever two result slots are
// free, so characters that give at most one result flow at one per cycle
// while out_stall is low, and the sustained rate for characters that give
// two results is bounded by the single result port. Words and comment runs
// saturate at 4096 characters.
`default_nettype none

module c_keyword_highlight_lexer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  char_code,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       color,
  output logic [12:0]      run_length,
  output logic             line_end,
  output logic             last
);

  logic [63:0] word_prefix, word_prefix_next;
  logic [ckhl_pkg::LEN_W-1:0] word_length, word_length_next;
  logic slash_pending, slash_pending_next;
  logic in_comment, in_comment_next;

  logic accept;
  logic room2;
  logic a_valid, b_valid;
  ckhl_pkg::result_t a_res, b_res, res0, res1, out_res;
  logic [1:0] res_n, push_n;
  logic [1:0] cur_color;
  logic ident;

  assign in_stall = !room2;
  assign accept = in_valid && !in_stall;
  assign cur_color = ckhl_pkg::word_color(word_prefix, word_length);
  assign ident = ckhl_pkg::is_ident(char_code);

  always_comb begin
    word_prefix_next = word_prefix;
    word_length_next = word_length;
    slash_pending_next = slash_pending;
    in_comment_next = in_comment;
    a_valid = 1'b0;
    b_valid = 1'b0;
    a_res = '{color: ckhl_pkg::COLOR_PLAIN, run_length: ckhl_pkg::LEN_W'(1),
              line_end: 1'b0, last: 1'b0};
    b_res = '{color: ckhl_pkg::COLOR_PLAIN, run_length: ckhl_pkg::LEN_W'(1),
              line_end: 1'b0, last: 1'b0};
    if (char_code == ckhl_pkg::CHAR_NEWLINE) begin
      if (in_comment) begin
        a_valid = 1'b1;
        a_res.color = ckhl_pkg::COLOR_COMMENT;
        a_res.run_length = word_length;
      end else if (slash_pending) begin
        a_valid = 1'b1;
      end else if (word_length != '0) begin
        a_valid = 1'b1;
        a_res.color = cur_color;
        a_res.run_length = word_length;
      end
      b_valid = 1'b1;
      b_res.run_length = '0;
      b_res.line_end = 1'b1;
      word_prefix_next = '0;
      word_length_next = '0;
      slash_pending_next = 1'b0;
      in_comment_next = 1'b0;
    end else if (in_comment) begin
      if (word_length < ckhl_pkg::RUN_CAP) word_length_next = word_length + ckhl_pkg::LEN_W'(1);
    end else if (slash_pending && char_code == ckhl_pkg::CHAR_SLASH) begin
      slash_pending_next = 1'b0;
      in_comment_next = 1'b1;
      word_prefix_next = '0;
      word_length_next = ckhl_pkg::COMMENT_START;
    end else begin
      if (slash_pending) begin
        a_valid = 1'b1;
        slash_pending_next = 1'b0;
      end
      if (ident) begin
        if (word_length < ckhl_pkg::PREFIX_CHARS) word_prefix_next = {word_prefix[55:0], char_code};
        if (word_length < ckhl_pkg::RUN_CAP) word_length_next = word_length + ckhl_pkg::LEN_W'(1);
      end else begin
        if (word_length != '0) begin
          a_valid = 1'b1;
          a_res.color = cur_color;
          a_res.run_length = word_length;
          word_prefix_next = '0;
          word_length_next = '0;
        end
        if (char_code == ckhl_pkg::CHAR_SLASH) slash_pending_next = 1'b1;
        else b_valid = 1'b1;
      end
    end

    res_n = 2'(a_valid) + 2'(b_valid);
    res0 = a_valid ? a_res : b_res;
    res1 = b_res;
    res0.last = (res_n == 2'd1);
    res1.last = 1'b1;
  end

  assign push_n = accept ? res_n : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_prefix <= '0;
      word_length <= '0;
      slash_pending <= 1'b0;
      in_comment <= 1'b0;
    end else if (accept) begin
      word_prefix <= word_prefix_next;
      word_length <= word_length_next;
      slash_pending <= slash_pending_next;
      in_comment <= in_comment_next;
    end
  end

  ckhl_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push0     (res0),
    .push1     (res1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign color = out_res.color;
  assign run_length = out_res.run_length;
  assign line_end = out_res.line_end;
  assign last = out_res.last;

endmodule

`default_nettype wire
